@@ design/spe_pkg.sv @@
// Shared constants and types of the sparse multivariate polynomial evaluator.
// Used by the multiplier, the RAM users and the top level; depends on nothing.
package spe_pkg;

	localparam int MAPS       = 16;
	localparam int FUNCS      = 4;
	localparam int TERMS      = 256;
	localparam int VARS       = 6;
	localparam int VAR_FIELDS = 6;
	localparam int TABLES     = MAPS * FUNCS;
	localparam int ENTRIES    = TABLES * TERMS;
	localparam int ADDR_W     = $clog2(ENTRIES);
	localparam int TERM_AW    = $clog2(TERMS);
	localparam int TERM_CW    = $clog2(TERMS + 1);
	localparam int Y_W        = $clog2(VARS + 1);
	localparam int YI_W       = $clog2(VAR_FIELDS);

	localparam int FRAC   = 24;
	localparam int QW     = 48;
	localparam int VW     = 32;
	localparam int EXP_W  = 3;
	localparam int ORD_W  = 3;
	localparam int EXPS_W = EXP_W * VAR_FIELDS;
	localparam int DESC_W = 1 + ORD_W + EXPS_W;
	localparam int DESC_VALID = DESC_W - 1;
	localparam int ACC_W  = QW + 3;

	localparam logic [ORD_W-1:0] ORDER_RESET = ORD_W'(5);
	localparam logic signed [QW-1:0] Q_ONE = QW'(1) << FRAC;
	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	typedef struct packed {
		logic done;
		logic clip;
	} qmul_stat_t;

endpackage

@@ design/sparse_multivariate_polynomial_eval.sv @@
// Top level of the sparse multivariate polynomial evaluator.
// Depends on spe_pkg, spe_ram and spe_qmul.
//
// Input channel (in_valid / in_stall): cmd 0 writes one term into table table_sel at
// term_index; cmd 1 evaluates table table_sel at var_0..var_5 and yields one result.
// Output channel (out_valid / out_stall): poly_value and saturated, one per evaluation.
// Config channel (cfg_valid / cfg_ready): cfg_data sets order_limit, reset value 5;
// cfg_ready is always high.
// For each term the evaluation steps through every variable: every power step and the
// coefficient product go through the one iterative multiplier, one Q.24 product at a
// time. A term is read from the term RAMs, whose read data is registered.
// After reset the block sweeps all 16384 descriptor RAM entries, one entry per
// cycle, clearing valid bits; in_stall stays high meanwhile.
// A finished result waits in the output register while out_stall is high; the next
// item is still taken, and a later evaluation holds at its end until the register frees.
module sparse_multivariate_polynomial_eval (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [5:0]                         table_sel,
	input  logic [7:0]                         term_index,
	input  logic [2:0]                         term_order,
	input  logic [17:0]                        exponents_packed,
	input  logic signed [47:0]                 coefficient,
	input  logic signed [31:0]                 var_0,
	input  logic signed [31:0]                 var_1,
	input  logic signed [31:0]                 var_2,
	input  logic signed [31:0]                 var_3,
	input  logic signed [31:0]                 var_4,
	input  logic signed [31:0]                 var_5,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [47:0]                 poly_value,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_data
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD, S_DESC, S_POW, S_PWAIT, S_TWAIT, S_ACC, S_FIN
	} state_t;

	state_t state_q;
	logic [spe_pkg::ADDR_W-1:0]      clr_q, base_q, rd_addr, wr_addr, d_waddr;
	logic [spe_pkg::TERM_CW-1:0]     t_q;
	logic [spe_pkg::Y_W-1:0]         y_q;
	logic [spe_pkg::EXP_W-1:0]       k_q, ex;
	logic [spe_pkg::ORD_W-1:0]       order_limit_q;
	logic signed [spe_pkg::QW-1:0]   var_q [spe_pkg::VAR_FIELDS];
	logic signed [spe_pkg::QW-1:0]   m_q, prod_q, acc_q, coef_q, coef_rd, qa, qb, qres;
	logic [spe_pkg::DESC_W-1:0]      desc_q, desc_rd, d_wdata;
	logic                            clip_q, out_valid_q, sat_q, qstart, in_acc, wr_ok, d_we;
	logic signed [spe_pkg::QW-1:0]   pv_q;
	logic signed [spe_pkg::QW:0]     sum;
	spe_pkg::qmul_stat_t             qstat;

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign wr_ok     = in_acc && cmd == spe_pkg::CMD_WRITE
		&& int'(table_sel) < spe_pkg::TABLES && int'(term_index) < spe_pkg::TERMS;
	assign wr_addr   = spe_pkg::ADDR_W'(int'(table_sel) * spe_pkg::TERMS + int'(term_index));
	assign rd_addr   = base_q + spe_pkg::ADDR_W'(t_q[spe_pkg::TERM_AW-1:0]);
	assign d_we      = state_q == S_CLEAR || wr_ok;
	assign d_waddr   = state_q == S_CLEAR ? clr_q : wr_addr;
	assign d_wdata   = state_q == S_CLEAR ? '0 : {1'b1, term_order, exponents_packed};
	assign ex        = desc_q[int'(y_q[spe_pkg::YI_W-1:0]) * spe_pkg::EXP_W +: spe_pkg::EXP_W];
	assign sum       = {acc_q[spe_pkg::QW-1], acc_q} + {prod_q[spe_pkg::QW-1], prod_q};

	spe_ram #(.WIDTH(spe_pkg::QW), .DEPTH(spe_pkg::ENTRIES)) u_coef_ram (
		.clk(clk), .we(wr_ok), .waddr(wr_addr), .wdata(coefficient),
		.raddr(rd_addr), .rdata(coef_rd)
	);

	spe_ram #(.WIDTH(spe_pkg::DESC_W), .DEPTH(spe_pkg::ENTRIES)) u_desc_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(rd_addr), .rdata(desc_rd)
	);

	always_comb begin
		qstart = 1'b0;
		qa = m_q;
		qb = var_q[y_q[spe_pkg::YI_W-1:0]];
		if (state_q == S_POW) begin
			if (int'(y_q) == spe_pkg::VARS) begin
				qstart = 1'b1;
				qa = coef_q;
				qb = m_q;
			end else if (k_q != ex) begin
				qstart = 1'b1;
			end
		end
	end

	spe_qmul u_qmul (
		.clk(clk), .arst_n(arst_n), .start(qstart), .a(qa), .b(qb), .res(qres), .stat(qstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			order_limit_q <= spe_pkg::ORDER_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_limit_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == spe_pkg::ADDR_W'(spe_pkg::ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && cmd == spe_pkg::CMD_EVAL) begin
						state_q <= int'(table_sel) < spe_pkg::TABLES ? S_RD : S_FIN;
					end
				end
				S_RD: state_q <= S_DESC;
				S_DESC: begin
					if (!desc_rd[spe_pkg::DESC_VALID]
						|| desc_rd[spe_pkg::DESC_W-2 -: spe_pkg::ORD_W] > order_limit_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_POW;
					end
				end
				S_POW: begin
					if (int'(y_q) == spe_pkg::VARS) begin
						state_q <= S_TWAIT;
					end else if (k_q != ex) begin
						state_q <= S_PWAIT;
					end
				end
				S_PWAIT: if (qstat.done) state_q <= S_POW;
				S_TWAIT: if (qstat.done) state_q <= S_ACC;
				S_ACC: begin
					state_q <= int'(t_q) + 1 == spe_pkg::TERMS ? S_FIN : S_RD;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				var_q[0] <= spe_pkg::QW'(var_0);
				var_q[1] <= spe_pkg::QW'(var_1);
				var_q[2] <= spe_pkg::QW'(var_2);
				var_q[3] <= spe_pkg::QW'(var_3);
				var_q[4] <= spe_pkg::QW'(var_4);
				var_q[5] <= spe_pkg::QW'(var_5);
				base_q   <= spe_pkg::ADDR_W'(int'(table_sel) * spe_pkg::TERMS);
				t_q      <= '0;
				acc_q    <= '0;
				clip_q   <= 1'b0;
			end
			S_DESC: begin
				desc_q <= desc_rd;
				coef_q <= coef_rd;
				m_q    <= spe_pkg::Q_ONE;
				y_q    <= '0;
				k_q    <= '0;
			end
			S_POW: begin
				if (int'(y_q) != spe_pkg::VARS && k_q == ex) begin
					y_q <= y_q + 1'b1;
					k_q <= '0;
				end
			end
			S_PWAIT: begin
				if (qstat.done) begin
					m_q    <= qres;
					clip_q <= clip_q | qstat.clip;
					k_q    <= k_q + 1'b1;
				end
			end
			S_TWAIT: begin
				if (qstat.done) begin
					prod_q <= qres;
					clip_q <= clip_q | qstat.clip;
				end
			end
			S_ACC: begin
				t_q <= t_q + 1'b1;
				if (sum[spe_pkg::QW] != sum[spe_pkg::QW-1]) begin
					acc_q  <= sum[spe_pkg::QW] ? spe_pkg::Q_MIN : spe_pkg::Q_MAX;
					clip_q <= 1'b1;
				end else begin
					acc_q <= sum[spe_pkg::QW-1:0];
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					pv_q  <= acc_q;
					sat_q <= clip_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign poly_value = pv_q;
	assign saturated  = sat_q;

endmodule

@@ design/spe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/spe_qmul.sv @@
// Iterative Q.24 multiplier: one 24x24 partial product per cycle, rounded and saturated.
// Depends on spe_pkg.
module spe_qmul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [spe_pkg::QW-1:0]      a,
	input  logic signed [spe_pkg::QW-1:0]      b,
	output logic signed [spe_pkg::QW-1:0]      res,
	output spe_pkg::qmul_stat_t                stat
);

	localparam int HW = spe_pkg::FRAC;

	logic [spe_pkg::QW-1:0]    ua_q, ub_q;
	logic                      neg_q;
	logic                      busy_q;
	logic [2:0]                step_q;
	logic [2*HW-1:0]           prod_q;
	logic [spe_pkg::ACC_W-1:0] acc_q;
	logic                      big_q;
	logic                      done_q, clip_q;
	logic signed [spe_pkg::QW-1:0] res_q;
	logic [HW-1:0]             x, y;
	logic [spe_pkg::ACC_W-1:0] lim, m;

	always_comb begin
		case (step_q)
			3'd0:    begin x = ua_q[2*HW-1:HW]; y = ub_q[2*HW-1:HW]; end
			3'd1:    begin x = ua_q[2*HW-1:HW]; y = ub_q[HW-1:0]; end
			3'd2:    begin x = ua_q[HW-1:0];    y = ub_q[2*HW-1:HW]; end
			default: begin x = ua_q[HW-1:0];    y = ub_q[HW-1:0]; end
		endcase
		lim = neg_q ? spe_pkg::ACC_W'({1'b1, {(spe_pkg::QW-1){1'b0}}})
		            : spe_pkg::ACC_W'({1'b0, {(spe_pkg::QW-1){1'b1}}});
		m = (big_q || acc_q > lim) ? lim : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
			clip_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					clip_q <= big_q || acc_q > lim;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= a[spe_pkg::QW-1] ? spe_pkg::QW'(-a) : a;
			ub_q  <= b[spe_pkg::QW-1] ? spe_pkg::QW'(-b) : b;
			neg_q <= a[spe_pkg::QW-1] ^ b[spe_pkg::QW-1];
			acc_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			prod_q <= x * y;
			case (step_q)
				3'd1: begin
					big_q <= prod_q[2*HW-1:HW] != '0;
					acc_q <= acc_q + spe_pkg::ACC_W'({prod_q[HW-1:0], {HW{1'b0}}});
				end
				3'd2, 3'd3: acc_q <= acc_q + spe_pkg::ACC_W'(prod_q);
				3'd4: acc_q <= acc_q
					+ spe_pkg::ACC_W'((spe_pkg::ACC_W'(prod_q) + spe_pkg::ACC_W'(1 << (HW - 1))) >> HW);
				3'd5: res_q <= neg_q ? spe_pkg::QW'(-m) : spe_pkg::QW'(m);
				default: ;
			endcase
		end
	end

	assign res  = res_q;
	assign stat = '{done: done_q, clip: clip_q};

endmodule

@@ design/spe_check.sv @@
// Port-level checker for the polynomial evaluator, bound to the top level.
// Depends on spe_pkg for command codes.
module spe_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] poly_value,
	input logic        saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(poly_value) && $stable(saturated))
		else $error("result changed while stalled");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == spe_pkg::CMD_EVAL |=> in_stall)
		else $error("evaluation did not hold off the next transfer");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == spe_pkg::CMD_WRITE && !out_valid |=> !out_valid)
		else $error("write produced a result");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result appeared without an evaluation");

endmodule

bind sparse_multivariate_polynomial_eval spe_check u_spe_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
	.out_valid(out_valid), .out_stall(out_stall), .poly_value(poly_value),
	.saturated(saturated)
);
